[sv/kfct_pkg.sv]
// Package for the keyed fetch cache tracker.
// Holds item structs, code enums, controller command/status structs and key normalization.
// No dependencies; kfct_ctrl, kfct_dp and the top level import it.
package kfct_pkg;

	localparam int KEY_W = 24;
	localparam int HDL_W = 32;
	localparam int WID_W = 7;
	localparam int HGT_W = 6;
	localparam int TOT_W = 5;

	typedef enum logic [1:0] {
		CMD_LOOKUP   = 2'd0,
		CMD_QUERY    = 2'd1,
		CMD_COMPLETE = 2'd2
	} cmd_code_t;

	typedef enum logic [1:0] {
		ES_EMPTY   = 2'd0,
		ES_PENDING = 2'd1,
		ES_READY   = 2'd2,
		ES_FAILED  = 2'd3
	} entry_state_t;

	typedef enum logic [3:0] {
		RS_HIT        = 4'd0,
		RS_PRESENT    = 4'd1,
		RS_CLAIMED    = 4'd2,
		RS_NO_SLOT    = 4'd3,
		RS_EMPTY_KEY  = 4'd4,
		RS_STORED     = 4'd5,
		RS_DISCARDED  = 4'd6,
		RS_PEND_FOUND = 4'd7,
		RS_PEND_NONE  = 4'd8
	} rsp_status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SEARCH,
		CS_RESP
	} ctl_state_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] key;
		logic [HDL_W-1:0] buffer_handle;
		logic [WID_W-1:0] image_width;
		logic [HGT_W-1:0] image_height;
		logic             fetch_ok;
	} in_item_t;

	typedef struct packed {
		logic [3:0]       status;
		logic [HDL_W-1:0] hit_handle;
		logic [WID_W-1:0] hit_width;
		logic [HGT_W-1:0] hit_height;
		logic             release_valid;
		logic [HDL_W-1:0] release_handle;
		logic [KEY_W-1:0] pending_key;
		logic [TOT_W-1:0] pending_total;
	} out_item_t;

	// one word of the entry table RAM
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [HDL_W-1:0] handle;
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
	} ram_word_t;

	typedef struct packed {
		logic capture;
		logic search;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// drop every character after the first zero byte
	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] k;
		k = raw;
		if (raw[7:0] == 8'd0) begin
			k = '0;
		end else if (raw[15:8] == 8'd0) begin
			k = {16'd0, raw[7:0]};
		end else if (raw[23:16] == 8'd0) begin
			k = {8'd0, raw[15:0]};
		end
		return k;
	endfunction

endpackage

[sv/kfct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kfct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/kfct_ctrl.sv]
// Sequencer of the keyed fetch cache tracker: capture, search, respond.
// Depends on kfct_pkg.
module kfct_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  kfct_pkg::dp_status_t sts,
	output kfct_pkg::ctl_cmd_t  cmd
);
	import kfct_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (req_valid) state_d = CS_SEARCH;
			end
			CS_SEARCH: begin
				state_d = CS_RESP;
			end
			CS_RESP: begin
				if (sts.out_free) state_d = req_valid ? CS_SEARCH : CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd         = '0;
		case (state_q)
			CS_IDLE: begin
				req_ready = 1'b1;
			end
			CS_SEARCH: begin
				cmd.search = 1'b1;
			end
			CS_RESP: begin
				// retire the item and take the next one in the same cycle
				req_ready  = sts.out_free;
				cmd.commit = sts.out_free;
			end
			default: ;
		endcase
		cmd.capture = req_valid && req_ready;
	end

endmodule

[sv/kfct_dp.sv]
// Datapath of the keyed fetch cache tracker: key CAM, entry states, table RAM, output register.
// Depends on kfct_pkg and kfct_ram.
module kfct_dp #(
	parameter int ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kfct_pkg::ctl_cmd_t   cmd,
	output kfct_pkg::dp_status_t sts,
	input  kfct_pkg::in_item_t   req,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	output kfct_pkg::out_item_t  rsp
);
	import kfct_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// captured item
	logic [1:0]       cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [HDL_W-1:0] hdl_q;
	logic [WID_W-1:0] wid_q;
	logic [HGT_W-1:0] hgt_q;
	logic             ok_q;

	// table state
	entry_state_t     stat_q [ENTRIES];
	logic [KEY_W-1:0] ckey_q [ENTRIES];
	logic [IDX_W-1:0] vp_q;
	logic [CNT_W-1:0] cnt_q;

	// search decision
	rsp_status_t      code_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             evict_s1;
	logic             rr_s1;

	logic             rsp_valid_q;
	out_item_t        rsp_q;

	logic [ENTRIES-1:0] match, emp, pnd, cand, cand_hi;
	logic               hit_any, emp_any, pnd_any, hi_any, lo_any;
	logic               hit_rdy, hit_pnd, hi_rdy, lo_rdy, rr_rdy;
	logic [IDX_W-1:0]   hit_idx, emp_idx, pnd_idx, hi_idx, lo_idx, rr_idx;

	rsp_status_t      code_d;
	logic [IDX_W-1:0] idx_d;
	logic             evict_d;
	logic             rr_d;

	ram_word_t        rd_word;
	ram_word_t        wr_word;
	logic             ram_we;
	out_item_t        res;
	logic [CNT_W-1:0] cnt_d;
	logic [31:0]      cnt_ext;
	logic [IDX_W-1:0] vp_next;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= req.command;
			key_q <= norm_key(req.key);
			hdl_q <= req.buffer_handle;
			wid_q <= req.image_width;
			hgt_q <= req.image_height;
			ok_q  <= req.fetch_ok;
		end
	end

	// tag compare and priority selects
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]   = (stat_q[i] != ES_EMPTY) && (ckey_q[i] == key_q);
			emp[i]     = (stat_q[i] == ES_EMPTY);
			pnd[i]     = (stat_q[i] == ES_PENDING);
			cand[i]    = (stat_q[i] != ES_PENDING);
			cand_hi[i] = cand[i] && (IDX_W'(i) >= vp_q);
		end
		hit_any = 1'b0; hit_idx = '0; hit_rdy = 1'b0; hit_pnd = 1'b0;
		emp_any = 1'b0; emp_idx = '0;
		pnd_any = 1'b0; pnd_idx = '0;
		hi_any  = 1'b0; hi_idx  = '0; hi_rdy = 1'b0;
		lo_any  = 1'b0; lo_idx  = '0; lo_rdy = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
				hit_rdy = (stat_q[i] == ES_READY);
				hit_pnd = pnd[i];
			end
			if (emp[i]) begin
				emp_any = 1'b1;
				emp_idx = IDX_W'(i);
			end
			if (pnd[i]) begin
				pnd_any = 1'b1;
				pnd_idx = IDX_W'(i);
			end
			if (cand_hi[i]) begin
				hi_any = 1'b1;
				hi_idx = IDX_W'(i);
				hi_rdy = (stat_q[i] == ES_READY);
			end
			if (cand[i]) begin
				lo_any = 1'b1;
				lo_idx = IDX_W'(i);
				lo_rdy = (stat_q[i] == ES_READY);
			end
		end
		// round robin: first candidate at or after the pointer, else wrap
		rr_idx = hi_any ? hi_idx : lo_idx;
		rr_rdy = hi_any ? hi_rdy : lo_rdy;
	end

	always_comb begin
		code_d  = RS_PEND_NONE;
		idx_d   = '0;
		evict_d = 1'b0;
		rr_d    = 1'b0;
		case (cmd_q)
			CMD_LOOKUP: begin
				if (key_q == '0) begin
					code_d = RS_EMPTY_KEY;
				end else if (hit_any) begin
					idx_d  = hit_idx;
					code_d = hit_rdy ? RS_HIT : RS_PRESENT;
				end else if (emp_any) begin
					idx_d  = emp_idx;
					code_d = RS_CLAIMED;
				end else if (lo_any) begin
					idx_d   = rr_idx;
					code_d  = RS_CLAIMED;
					rr_d    = 1'b1;
					evict_d = rr_rdy;
				end else begin
					code_d = RS_NO_SLOT;
				end
			end
			CMD_COMPLETE: begin
				if ((key_q != '0) && hit_any && hit_pnd) begin
					idx_d  = hit_idx;
					code_d = RS_STORED;
				end else begin
					code_d = RS_DISCARDED;
				end
			end
			default: begin
				if (pnd_any) begin
					idx_d  = pnd_idx;
					code_d = RS_PEND_FOUND;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			code_s1  <= code_d;
			idx_s1   <= idx_d;
			evict_s1 <= evict_d;
			rr_s1    <= rr_d;
		end
	end

	kfct_ram #(
		.WIDTH($bits(ram_word_t)),
		.DEPTH(ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (wr_word),
		.re    (cmd.search),
		.raddr (idx_d),
		.rdata (rd_word)
	);

	always_comb begin
		ram_we  = cmd.commit && ((code_s1 == RS_CLAIMED) || (code_s1 == RS_STORED));
		wr_word = '0;
		wr_word.key = key_q;
		if (code_s1 == RS_STORED) begin
			wr_word.handle = ok_q ? hdl_q : '0;
			wr_word.width  = wid_q;
			wr_word.height = hgt_q;
		end
	end

	// result and next pending count
	always_comb begin
		res        = '0;
		res.status = code_s1;
		cnt_d      = cnt_q;
		case (code_s1)
			RS_HIT: begin
				res.hit_handle = rd_word.handle;
				res.hit_width  = rd_word.width;
				res.hit_height = rd_word.height;
			end
			RS_CLAIMED: begin
				res.release_valid  = evict_s1;
				res.release_handle = evict_s1 ? rd_word.handle : '0;
				cnt_d              = cnt_q + CNT_W'(1);
			end
			RS_STORED: begin
				cnt_d = (cnt_q != '0) ? cnt_q - CNT_W'(1) : cnt_q;
			end
			RS_DISCARDED: begin
				res.release_valid  = ok_q;
				res.release_handle = ok_q ? hdl_q : '0;
			end
			RS_PEND_FOUND: begin
				res.pending_key = rd_word.key;
			end
			RS_PEND_NONE: begin
				cnt_d = '0;
			end
			default: ;
		endcase
		cnt_ext           = 32'(cnt_d);
		res.pending_total = (cnt_ext > 32'd31) ? 5'd31 : cnt_ext[TOT_W-1:0];
		vp_next           = (idx_s1 == IDX_W'(ENTRIES - 1)) ? '0 : idx_s1 + IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				stat_q[i] <= ES_EMPTY;
			end
			vp_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.commit) begin
			cnt_q <= cnt_d;
			if (code_s1 == RS_CLAIMED) begin
				stat_q[idx_s1] <= ES_PENDING;
				if (rr_s1) vp_q <= vp_next;
			end else if (code_s1 == RS_STORED) begin
				stat_q[idx_s1] <= ok_q ? ES_READY : ES_FAILED;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (code_s1 == RS_CLAIMED)) begin
			ckey_q[idx_s1] <= key_q;
		end
	end

	// output register
	assign sts.out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/keyed_fetch_cache_tracker.sv]
// Keyed fetch cache tracker, top level. An accepted item is tag-searched, which starts the
// registered read of the entry table RAM, then committed to the output register once that is
// free; a full output register stalls the item. A new item is not taken before the last commits.
// Reset (arst_n low, asynchronous): all entries empty, victim pointer and pending count zero,
// output register empty. No clearing pass; items are accepted right after reset.
// Depends on kfct_pkg, kfct_ctrl, kfct_dp and kfct_ram.
module keyed_fetch_cache_tracker #(
	parameter int ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  kfct_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output kfct_pkg::out_item_t rsp
);
	import kfct_pkg::*;

	// Command and status between sequencer and datapath:
	//   capture - latch the item and normalize its key
	//   search  - compare all tags, pick the entry, start the table read
	//   commit  - update entry state, write the table, load the output register
	ctl_cmd_t   ctl_cmd;
	dp_status_t dp_sts;

	kfct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (dp_sts),
		.cmd       (ctl_cmd)
	);

	// The datapath holds entry states in flops (so reset empties the table at once),
	// keys in a parallel-compare array, and handle/size/key copies in the table RAM.
	kfct_dp #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.sts       (dp_sts),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// Hold off the next item while one is being searched.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted during search");

	// A committed item shows up at the output on the next cycle.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.commit |=> rsp_valid)
		else $error("committed item not presented");

	// Hit fields carry data only for a ready hit.
	a_hit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != RS_HIT) |->
		(rsp.hit_handle == '0) && (rsp.hit_width == '0) && (rsp.hit_height == '0))
		else $error("hit fields set without a hit");

	// Release handle is zero unless a buffer is released.
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.release_valid |-> (rsp.release_handle == '0))
		else $error("release handle without release");

endmodule
